[rtl/tlbt_pkg.sv]
// Shared constants for the TLB and page-table address translator.
// Fixed field widths and default parameter values; no dependencies.
package tlbt_pkg;

  // Fixed widths of the item fields.
  localparam int unsigned VA_W  = 16;
  localparam int unsigned CNT_W = 32;

  // Default geometry of the translator.
  localparam int unsigned TLB_DEPTH_DEF   = 16;
  localparam int unsigned PAGE_COUNT_DEF  = 256;
  localparam int unsigned FRAME_COUNT_DEF = 256;
  localparam int unsigned OFFSET_BITS_DEF = 8;

endpackage : tlbt_pkg

[rtl/tlbt_if.sv]
// Valid/ready channel interfaces of the translator: virtual address in, result out.
// Depends on tlbt_pkg for the field widths.
interface tlbt_va_if import tlbt_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [VA_W-1:0] vaddr;

  modport source (output valid, output vaddr, input ready);
  modport sink   (input valid, input vaddr, output ready);
endinterface : tlbt_va_if

interface tlbt_res_if import tlbt_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [VA_W-1:0]  paddr;
  logic             tlb_hit;
  logic             page_fault;
  logic             no_free_frame;
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] fault_count;

  modport source (output valid, output paddr, output tlb_hit, output page_fault,
                  output no_free_frame, output hit_count, output fault_count, input ready);
  modport sink   (input valid, input paddr, input tlb_hit, input page_fault,
                  input no_free_frame, input hit_count, input fault_count, output ready);
endinterface : tlbt_res_if

[rtl/tlb_page_table_translator_core.sv]
// Top level of the TLB and page-table address translator.
// Depends on tlbt_pkg and on the channel interfaces in tlbt_if.sv.
//
// Usage: virtual addresses arrive as items on va_i and one result item per address
// leaves on res_o; both channels move an item when valid and ready are high at a
// rising clock edge. Each result carries the physical address, the TLB hit, page
// fault and out-of-frames flags, and the saturating hit and fault counts.
// Flow: an accepted item passes through the lookup state, where the synchronous
// read of the page map precedes the allocate and write-back decision, and its result
// is then held in the output register. When PAGE_COUNT is neither a power of two nor
// larger than the page-number range, a wrap state before the lookup wraps the page
// number. The block works on one item at a time and takes no new address until the
// last one has committed.
// Reset: the TLB, allocator and counters clear at once; the page map is then swept
// to invalid one entry per cycle over all PAGE_COUNT entries, and va_i.ready stays
// low until the sweep is done.
// Stall: the result sits in an output register; while the receiver holds ready low
// the next item may still be accepted and read, but its commit waits until the
// output register is free.
module tlb_page_table_translator_core import tlbt_pkg::*; #(
  parameter int unsigned TLB_DEPTH   = TLB_DEPTH_DEF,
  parameter int unsigned PAGE_COUNT  = PAGE_COUNT_DEF,
  parameter int unsigned FRAME_COUNT = FRAME_COUNT_DEF,
  parameter int unsigned OFFSET_BITS = OFFSET_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  tlbt_va_if.sink    va_i,
  tlbt_res_if.source res_o
);

  localparam int unsigned TLB_W   = $clog2(TLB_DEPTH);
  localparam int unsigned PAGE_W  = $clog2(PAGE_COUNT);
  localparam int unsigned FRAME_W = $clog2(FRAME_COUNT);
  // Page-number width; at least one bit so that a full-width offset still elaborates.
  localparam int unsigned VPN_W   = (OFFSET_BITS < VA_W) ? VA_W - OFFSET_BITS : 1;
  // The page number needs no wrap logic when a plain truncation or extension suffices.
  localparam bit DIRECT = ((PAGE_COUNT & (PAGE_COUNT - 1)) == 0) ||
                          (PAGE_COUNT >= (1 << VPN_W));
  // Reciprocal for the page-number wrap: quotient estimate is exact or one low.
  localparam int unsigned SH     = VPN_W + PAGE_W;
  localparam int unsigned RECIP  = (1 << SH) / PAGE_COUNT;
  localparam int unsigned PROD_W = VPN_W + SH;
  localparam int unsigned REM_W  = VPN_W + 1;
  localparam int unsigned CAT_W  = FRAME_W + OFFSET_BITS;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } map_entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRAP,
    ST_LOOKUP
  } state_e;

  state_e state_q;
  logic [PAGE_W-1:0]      clr_idx_q;
  logic [VPN_W-1:0]       vpn_q;
  logic [VPN_W-1:0]       quo_q;
  logic [OFFSET_BITS-1:0] off_q;
  logic [PAGE_W-1:0]      page_q;

  // TLB entries live in flip-flops so that every entry can be compared at once.
  logic                   tlb_valid_q [TLB_DEPTH];
  logic [PAGE_W-1:0]      tlb_page_q  [TLB_DEPTH];
  logic [FRAME_W-1:0]     tlb_frame_q [TLB_DEPTH];
  logic [TLB_W-1:0]       tlb_wp_q;

  logic [FRAME_W-1:0]     next_frame_q;
  logic                   exhausted_q;
  logic [CNT_W-1:0]       hit_cnt_q;
  logic [CNT_W-1:0]       fault_cnt_q;

  logic                   out_valid_q;
  logic [VA_W-1:0]        phys_q;
  logic                   hit_q;
  logic                   fault_q;
  logic                   nofree_q;

  // Page map memory with registered read data.
  map_entry_t             map_mem [PAGE_COUNT];
  map_entry_t             map_rd_q;

  logic                   in_accept;
  logic [VPN_W-1:0]       va_vpn;
  logic [OFFSET_BITS-1:0] va_off;
  logic [PROD_W-1:0]      quo_prod;
  logic [VPN_W-1:0]       quo_d;
  logic [REM_W-1:0]       qp;
  logic [REM_W-1:0]       rem_raw;
  logic [REM_W-1:0]       rem;
  logic [PAGE_W-1:0]      wrap_page;

  logic                   rd_en;
  logic [PAGE_W-1:0]      rd_addr;
  logic                   wr_en;
  logic [PAGE_W-1:0]      wr_addr;
  map_entry_t             wr_data;

  logic                   tlb_match;
  logic [FRAME_W-1:0]     tlb_match_frame;
  logic                   commit;
  logic                   have_frame;
  logic                   do_fault;
  logic                   do_nofree;
  logic                   do_alloc;
  logic                   do_insert;
  logic [FRAME_W-1:0]     frame_sel;
  logic [CAT_W-1:0]       phys_cat;
  logic [VA_W-1:0]        phys_d;

  // Input side: one item at a time, taken only once the page map sweep is over.
  assign va_i.ready = (state_q == ST_IDLE);
  assign in_accept  = va_i.valid && va_i.ready;
  assign va_vpn     = VPN_W'(va_i.vaddr >> OFFSET_BITS);
  assign va_off     = va_i.vaddr[OFFSET_BITS-1:0];

  // Page-number wrap: the quotient estimate is registered at acceptance, the
  // remainder and its single correction are formed in the wrap cycle.
  assign quo_prod  = PROD_W'(va_vpn) * PROD_W'(RECIP);
  assign quo_d     = VPN_W'(quo_prod >> SH);
  assign qp        = REM_W'(quo_q) * REM_W'(PAGE_COUNT);
  assign rem_raw   = REM_W'(vpn_q) - qp;
  assign rem       = (rem_raw >= REM_W'(PAGE_COUNT)) ? rem_raw - REM_W'(PAGE_COUNT) : rem_raw;
  assign wrap_page = PAGE_W'(rem);

  // The page map is read once per item, either at acceptance or after the wrap.
  assign rd_en   = (in_accept && DIRECT) || (state_q == ST_WRAP);
  assign rd_addr = (state_q == ST_WRAP) ? wrap_page : PAGE_W'(va_vpn);

  // Fully associative TLB search; the lowest matching entry wins.
  always_comb begin
    tlb_match       = 1'b0;
    tlb_match_frame = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (tlb_valid_q[i] && (tlb_page_q[i] == page_q)) begin
        tlb_match       = 1'b1;
        tlb_match_frame = tlb_frame_q[i];
      end
    end
  end

  // The lookup commits only when the output register can take the result, so the
  // counters shown on the output always belong to the result being held.
  assign commit = (state_q == ST_LOOKUP) && (!out_valid_q || res_o.ready);

  always_comb begin
    have_frame = 1'b0;
    do_fault   = 1'b0;
    do_nofree  = 1'b0;
    do_alloc   = 1'b0;
    do_insert  = 1'b0;
    frame_sel  = tlb_match_frame;
    if (tlb_match) begin
      have_frame = 1'b1;
    end else if (map_rd_q.valid) begin
      frame_sel  = map_rd_q.frame;
      do_insert  = 1'b1;
      have_frame = 1'b1;
    end else begin
      do_fault = 1'b1;
      if (exhausted_q) begin
        do_nofree = 1'b1;
      end else begin
        frame_sel  = next_frame_q;
        do_alloc   = 1'b1;
        do_insert  = 1'b1;
        have_frame = 1'b1;
      end
    end
  end

  // Frame and offset joined, then cut or padded to the address width.
  assign phys_cat = {frame_sel, off_q};
  assign phys_d   = have_frame ? VA_W'(phys_cat) : '0;

  // One write port serves both the reset sweep and new allocations.
  assign wr_en   = (state_q == ST_CLEAR) || (commit && do_alloc);
  assign wr_addr = (state_q == ST_CLEAR) ? clr_idx_q : page_q;
  assign wr_data = (state_q == ST_CLEAR) ? map_entry_t'('0) : map_entry_t'{1'b1, next_frame_q};

  // A write and the next read of the same entry never fall on the same edge, since
  // the commit returns to idle before another item is accepted.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      map_rd_q <= map_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_idx_q    <= '0;
      vpn_q        <= '0;
      quo_q        <= '0;
      off_q        <= '0;
      page_q       <= '0;
      for (int i = 0; i < TLB_DEPTH; i++) begin
        tlb_valid_q[i] <= 1'b0;
        tlb_page_q[i]  <= '0;
        tlb_frame_q[i] <= '0;
      end
      tlb_wp_q     <= '0;
      next_frame_q <= '0;
      exhausted_q  <= 1'b0;
      hit_cnt_q    <= '0;
      fault_cnt_q  <= '0;
      out_valid_q  <= 1'b0;
      phys_q       <= '0;
      hit_q        <= 1'b0;
      fault_q      <= 1'b0;
      nofree_q     <= 1'b0;
    end else begin
      if (res_o.valid && res_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          if (clr_idx_q == PAGE_W'(PAGE_COUNT - 1)) begin
            state_q <= ST_IDLE;
          end else begin
            clr_idx_q <= clr_idx_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            vpn_q   <= va_vpn;
            quo_q   <= quo_d;
            off_q   <= va_off;
            page_q  <= PAGE_W'(va_vpn);
            state_q <= DIRECT ? ST_LOOKUP : ST_WRAP;
          end
        end
        ST_WRAP: begin
          page_q  <= wrap_page;
          state_q <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          if (commit) begin
            out_valid_q <= 1'b1;
            phys_q      <= phys_d;
            hit_q       <= tlb_match;
            fault_q     <= do_fault;
            nofree_q    <= do_nofree;
            if (tlb_match && (hit_cnt_q != '1)) begin
              hit_cnt_q <= hit_cnt_q + 1'b1;
            end
            if (do_fault && (fault_cnt_q != '1)) begin
              fault_cnt_q <= fault_cnt_q + 1'b1;
            end
            if (do_insert) begin
              tlb_valid_q[tlb_wp_q] <= 1'b1;
              tlb_page_q[tlb_wp_q]  <= page_q;
              tlb_frame_q[tlb_wp_q] <= frame_sel;
              tlb_wp_q <= (tlb_wp_q == TLB_W'(TLB_DEPTH - 1)) ? '0 : tlb_wp_q + 1'b1;
            end
            if (do_alloc) begin
              if (next_frame_q == FRAME_W'(FRAME_COUNT - 1)) begin
                exhausted_q <= 1'b1;
              end else begin
                next_frame_q <= next_frame_q + 1'b1;
              end
            end
            state_q <= ST_IDLE;
          end
        end
      endcase
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.paddr         = phys_q;
  assign res_o.tlb_hit       = hit_q;
  assign res_o.page_fault    = fault_q;
  assign res_o.no_free_frame = nofree_q;
  assign res_o.hit_count     = hit_cnt_q;
  assign res_o.fault_count   = fault_cnt_q;

endmodule : tlb_page_table_translator_core
